### rtl/core/hsl_to_rgb_converter_assert.svh
// Assertion macros for the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Checked at every rising clock edge while the block is out of reset.
`define HSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define HSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

  localparam logic [16:0] HUE_TURN = 17'd360;
  localparam logic [16:0] HUE_OFFSET = 17'd33120;
  localparam logic [16:0] RECIP_360 = 17'd93207;
  localparam int unsigned RECIP_360_SHIFT = 25;
  localparam int unsigned STAGES = 6;
  localparam int unsigned CHANNELS = 3;

  typedef enum logic [1:0] {
    RAMP_UP   = 2'd0,
    HOLD_HI   = 2'd1,
    RAMP_DOWN = 2'd2,
    HOLD_LO   = 2'd3
  } region_e;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] light;
    logic       black;
    logic       grey;
  } side_t;

endpackage

### rtl/core/hsl_to_rgb_converter.sv
// HSL to RGB pixel converter with alpha pass-through.
// The input channel (in_valid_i, in_ready_o) carries one pixel per transaction: a signed
// hue in degrees, saturation, lightness and alpha. The output channel (out_valid_o,
// out_ready_i) returns one RGB pixel with the same alpha for every input transaction, in
// order. Both channels follow the valid/ready rule: a transaction completes at a clock
// edge where valid and ready are both high.
// The datapath is a six-stage pipeline; when nothing stalls, one pixel is taken and one
// returned every cycle.
// The stages are: the hue quotient by 360, the hue remainder with the lightness and
// saturation fractions, the hue fraction with the lightness-saturation product, the two
// ramp levels with the per-channel hue regions, one ramp multiplier per channel, and the
// final byte conversion in the output register.
// Each stage holds its own valid bit and loads whenever it is empty or the stage after
// it moves on, so gaps in the stream close up while the receiver stalls and the input
// keeps being taken until all six stages are full. in_ready_o then falls until the
// receiver takes the oldest pixel. Nothing is dropped or repeated.
// Reset clears every valid bit; the data registers are not reset.
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  lightness_i,
  input  logic [7:0]  alpha_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_out_o
);

  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned FW = F + 1;
  localparam int unsigned GW = F + 2;
  localparam int unsigned TW = F + 3;
  localparam int unsigned XW = F + 4;
  localparam int unsigned BW = F + 10;
  localparam int unsigned LW = F + 17;
  localparam int unsigned HW = F + 18;
  localparam int unsigned PW = 2 * FW;

  localparam logic [FW-1:0] ONE = {1'b1, {F{1'b0}}};
  localparam longint unsigned THIRD_L = (64'd1 << F) / 64'd3;
  localparam longint unsigned TWO_THIRDS_L = (64'd2 << F) / 64'd3;
  localparam longint unsigned R255_L = ((64'd1 << (F + 16)) + 64'd254) / 64'd255;
  localparam longint unsigned R359_L = ((64'd1 << (F + 17)) + 64'd358) / 64'd359;
  localparam logic [FW-1:0] THIRD = THIRD_L[FW-1:0];
  localparam logic [FW-1:0] TWO_THIRDS = TWO_THIRDS_L[FW-1:0];
  localparam logic [F+8:0] R255 = R255_L[F+8:0];
  localparam logic [F+8:0] R359 = R359_L[F+8:0];
  localparam logic signed [TW-1:0] ONE_S = $signed(TW'(ONE));
  localparam logic signed [TW-1:0] THIRD_S = $signed(TW'(THIRD));

  logic [STAGES-1:0] vld_q, vld_d, en;
  side_t             side_q [STAGES];

  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= '{alpha: alpha_in_i, light: lightness_i,
                     black: (lightness_i == 8'd0), grey: (saturation_i == 8'd0)};
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 1: the hue is lifted by a multiple of 360 and divided by reciprocal.
  logic [16:0] hue_shift;
  logic [33:0] hue_scaled;
  logic [16:0] s1_u_q;
  logic [7:0]  s1_quo_q;
  logic [7:0]  s1_sat_q;

  assign hue_shift = {hue_i[15], hue_i} + HUE_OFFSET;
  assign hue_scaled = 34'(hue_shift) * 34'(RECIP_360);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_u_q   <= hue_shift;
      s1_quo_q <= hue_scaled[RECIP_360_SHIFT +: 8];
      s1_sat_q <= saturation_i;
    end
  end

  // Stage 2: hue remainder, lightness and saturation fractions.
  logic [16:0]   hue_rem;
  logic [LW-1:0] l_scaled, s_scaled;
  logic [8:0]    s2_hm_q;
  logic [FW-1:0] s2_fl_q, s2_fs_q;

  assign hue_rem = s1_u_q - 17'(s1_quo_q) * HUE_TURN;
  assign l_scaled = LW'(side_q[0].light) * LW'(R255);
  assign s_scaled = LW'(s1_sat_q) * LW'(R255);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_hm_q <= hue_rem[8:0];
      s2_fl_q <= l_scaled[F+16:16];
      s2_fs_q <= s_scaled[F+16:16];
    end
  end

  // Stage 3: hue fraction and the lightness-saturation product.
  logic [HW-1:0] h_scaled;
  logic [PW-1:0] ls_prod;
  logic [FW-1:0] s3_fh_q, s3_fl_q, s3_fs_q, s3_prod_q;

  assign h_scaled = HW'(s2_hm_q) * HW'(R359);
  assign ls_prod = PW'(s2_fl_q) * PW'(s2_fs_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_fh_q   <= h_scaled[F+17:17];
      s3_fl_q   <= s2_fl_q;
      s3_fs_q   <= s2_fs_q;
      s3_prod_q <= ls_prod[2*F:F];
    end
  end

  // Stage 4: ramp levels and per-channel region and ramp operand.
  logic [GW-1:0]          hi_d, lo_d;
  logic signed [GW:0]     lo_raw;
  logic [GW-1:0]          s4_hi_q, s4_lo_q;
  region_e                s4_region_q [CHANNELS];
  logic [FW-1:0]          s4_m_q [CHANNELS];

  always_comb begin
    if ((GW'(s3_fl_q) << 1) < GW'(ONE)) begin
      hi_d = GW'(s3_fl_q) + GW'(s3_prod_q);
    end else begin
      hi_d = GW'(s3_fl_q) + GW'(s3_fs_q) - GW'(s3_prod_q);
    end
    lo_raw = $signed((GW + 1)'(s3_fl_q) << 1) - $signed((GW + 1)'(hi_d));
    lo_d = (lo_raw < 0) ? '0 : lo_raw[GW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_hi_q <= hi_d;
      s4_lo_q <= lo_d;
    end
  end

  // Stage 5: ramp multiplier per channel.
  logic [GW-1:0] s5_hi_q, s5_lo_q;
  logic [FW-1:0] s5_ramp_q [CHANNELS];
  region_e       s5_region_q [CHANNELS];
  logic [GW-1:0] span;

  assign span = s4_hi_q - s4_lo_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_hi_q <= s4_hi_q;
      s5_lo_q <= s4_lo_q;
    end
  end

  // Stage 6: channel level, byte conversion and the black and grey cases.
  logic [7:0] s6_rgb_q [CHANNELS];

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    logic signed [TW-1:0] offs, t_raw, t_adj;
    logic [FW-1:0]        t;
    logic [XW-1:0]        six_t, three_t, six_down;
    logic [FW-1:0]        down;
    region_e              region_d;
    logic [FW-1:0]        m_d;
    logic [PW-1:0]        ramp_prod;
    logic [GW-1:0]        level;
    logic [BW-1:0]        scaled;
    logic [BW-1:0]        byte_v;
    logic [7:0]           rgb_d;

    assign offs = (ch == 0) ? THIRD_S : (ch == 1) ? '0 : -THIRD_S;

    always_comb begin
      t_raw = $signed(TW'(s3_fh_q)) + offs;
      if (t_raw < 0) begin
        t_adj = t_raw + ONE_S;
      end else if (t_raw > ONE_S) begin
        t_adj = t_raw - ONE_S;
      end else begin
        t_adj = t_raw;
      end
      t = t_adj[F:0];
      six_t = (XW'(t) << 2) + (XW'(t) << 1);
      three_t = (XW'(t) << 1) + XW'(t);
      down = TWO_THIRDS - t;
      six_down = (XW'(down) << 2) + (XW'(down) << 1);
      if (six_t < XW'(ONE)) begin
        region_d = RAMP_UP;
        m_d = six_t[F:0];
      end else if ((XW'(t) << 1) < XW'(ONE)) begin
        region_d = HOLD_HI;
        m_d = '0;
      end else if (three_t < (XW'(ONE) << 1)) begin
        region_d = RAMP_DOWN;
        m_d = six_down[F:0];
      end else begin
        region_d = HOLD_LO;
        m_d = '0;
      end
    end

    assign ramp_prod = PW'(span[F:0]) * PW'(s4_m_q[ch]);

    always_comb begin
      case (s5_region_q[ch]) inside
        RAMP_UP, RAMP_DOWN: level = s5_lo_q + GW'(s5_ramp_q[ch]);
        HOLD_HI:            level = s5_hi_q;
        default:            level = s5_lo_q;
      endcase
      if (level > GW'(ONE)) begin
        level = GW'(ONE);
      end
      scaled = (BW'(level) << 8) - BW'(level);
      byte_v = scaled >> F;
      if (side_q[4].black) begin
        rgb_d = 8'd0;
      end else if (side_q[4].grey) begin
        rgb_d = side_q[4].light;
      end else if (byte_v > BW'(255)) begin
        rgb_d = 8'd255;
      end else begin
        rgb_d = byte_v[7:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[3]) begin
        s4_region_q[ch] <= region_d;
        s4_m_q[ch]      <= m_d;
      end
      if (en[4]) begin
        s5_region_q[ch] <= s4_region_q[ch];
        s5_ramp_q[ch]   <= ramp_prod[2*F:F];
      end
      if (en[5]) begin
        s6_rgb_q[ch] <= rgb_d;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[STAGES-1];
  assign red_o       = s6_rgb_q[0];
  assign green_o     = s6_rgb_q[1];
  assign blue_o      = s6_rgb_q[2];
  assign alpha_out_o = side_q[STAGES-1].alpha;

  `HSL_ASSERT(a_hue_reduced, vld_q[1] |-> (17'(s2_hm_q) < HUE_TURN), "hue remainder out of range")
  `HSL_ASSERT(a_hue_frac_max, vld_q[2] |-> (s3_fh_q <= ONE), "hue fraction above one")
  `HSL_ASSERT(a_ramp_order, vld_q[3] |-> (s4_lo_q <= s4_hi_q), "ramp low level above high level")
  `HSL_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (vld_q == '0), "pipeline not empty in reset")

endmodule

### bench/hsl_to_rgb_converter_tb.sv
module hsl_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint THIRD = ONE / 3;
  localparam longint TWO_THIRDS = (2 * ONE) / 3;
  localparam int RANDOM_PIXELS = 1500;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 100;
  localparam int DIR_N = 23;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgb_pixel_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  light;
    logic [7:0]  alpha;
    logic        known;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] hue_i;
  logic [7:0]  saturation_i;
  logic [7:0]  lightness_i;
  logic [7:0]  alpha_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_out_o;

  rgb_pixel_t rgb_expect_q[$];
  int         err_count = 0;
  int         rx_count = 0;
  bit         tx_idle = 1'b1;
  bit         rx_idle = 1'b1;

  // Rows with known set carry a result that follows directly from black or grey.
  dir_row_t dir_tab [DIR_N] = '{
    '{16'h0000, 8'd255, 8'd0,   8'h5A, 1'b1, 8'd0,   8'd0,   8'd0},
    '{16'h8000, 8'd0,   8'd0,   8'hFF, 1'b1, 8'd0,   8'd0,   8'd0},
    '{16'h0000, 8'd0,   8'd255, 8'h00, 1'b1, 8'd255, 8'd255, 8'd255},
    '{16'd120,  8'd0,   8'd1,   8'hFF, 1'b1, 8'd1,   8'd1,   8'd1},
    '{16'h7FFF, 8'd0,   8'd128, 8'h33, 1'b1, 8'd128, 8'd128, 8'd128},
    '{16'd0,    8'd255, 8'd128, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd120,  8'd255, 8'd128, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd240,  8'd255, 8'd128, 8'h11, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd60,   8'd255, 8'd128, 8'h22, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd180,  8'd255, 8'd128, 8'h44, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd300,  8'd255, 8'd128, 8'h55, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd359,  8'd255, 8'd128, 8'h66, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd360,  8'd255, 8'd128, 8'h77, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'hFFFF, 8'd255, 8'd128, 8'h88, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'hFE98, 8'd255, 8'd128, 8'h99, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'h8000, 8'd255, 8'd255, 8'hAA, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'h7FFF, 8'd1,   8'd1,   8'hBB, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd30,   8'd255, 8'd1,   8'hCC, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd90,   8'd128, 8'd200, 8'hDD, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd210,  8'd200, 8'd60,  8'hEE, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'd330,  8'd1,   8'd254, 8'h01, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'h8000, 8'd128, 8'd127, 8'h80, 1'b0, 8'd0, 8'd0, 8'd0},
    '{16'h7FFF, 8'd255, 8'd64,  8'h7F, 1'b0, 8'd0, 8'd0, 8'd0}
  };

  hsl_to_rgb_converter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .alpha_in_i   (alpha_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_out_o  (alpha_out_o)
  );

  function automatic longint ramp_level(longint lo, longint hi, longint t);
    longint c;
    if (t < 0) begin
      t += ONE;
    end
    if (t > ONE) begin
      t -= ONE;
    end
    if (6 * t < ONE) begin
      c = lo + (((hi - lo) * t * 6) >>> FRAC);
    end else if (2 * t < ONE) begin
      c = hi;
    end else if (3 * t < 2 * ONE) begin
      c = lo + (((hi - lo) * (TWO_THIRDS - t) * 6) >>> FRAC);
    end else begin
      c = lo;
    end
    if (c < 0) begin
      c = 0;
    end
    if (c > ONE) begin
      c = ONE;
    end
    return c;
  endfunction

  function automatic logic [7:0] level_to_byte(longint c);
    longint v;
    v = (c * 255) >>> FRAC;
    if (v < 0) begin
      v = 0;
    end
    if (v > 255) begin
      v = 255;
    end
    return v[7:0];
  endfunction

  function automatic rgb_pixel_t hsl_to_rgb_predict(logic [15:0] hue, logic [7:0] sat,
                                                    logic [7:0] light, logic [7:0] alpha);
    rgb_pixel_t px;
    int         deg;
    longint     fh;
    longint     fl;
    longint     fs;
    longint     prod;
    longint     lo;
    longint     hi;
    deg = int'($signed(hue)) % 360;
    if (deg < 0) begin
      deg += 360;
    end
    px.alpha = alpha;
    if (light == 8'd0) begin
      px.red = 8'd0;
      px.green = 8'd0;
      px.blue = 8'd0;
    end else if (sat == 8'd0) begin
      px.red = light;
      px.green = light;
      px.blue = light;
    end else begin
      fh = (longint'(deg) * ONE) / 359;
      fl = (longint'(light) * ONE) / 255;
      fs = (longint'(sat) * ONE) / 255;
      prod = (fl * fs) >>> FRAC;
      if (2 * fl < ONE) begin
        hi = fl + prod;
      end else begin
        hi = fl + fs - prod;
      end
      lo = 2 * fl - hi;
      if (lo < 0) begin
        lo = 0;
      end
      px.red = level_to_byte(ramp_level(lo, hi, fh + THIRD));
      px.green = level_to_byte(ramp_level(lo, hi, fh));
      px.blue = level_to_byte(ramp_level(lo, hi, fh - THIRD));
    end
    return px;
  endfunction

  task automatic offer_pixel(input dir_row_t row);
    int         gap;
    rgb_pixel_t want;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    hue_i <= row.hue;
    saturation_i <= row.sat;
    lightness_i <= row.light;
    alpha_in_i <= row.alpha;
    do @(posedge clk_i); while (!in_ready_o);
    if (row.known) begin
      want = '{red: row.red, green: row.green, blue: row.blue, alpha: row.alpha};
    end else begin
      want = hsl_to_rgb_predict(row.hue, row.sat, row.light, row.alpha);
    end
    rgb_expect_q.push_back(want);
    if ($urandom_range(0, 63) == 0) begin
      tx_idle = !tx_idle;
    end
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("hsl_to_rgb_converter_tb NOT OK");
    $finish;
  end

  // The receiver stalls once for a long stretch so that the pipeline fills and
  // pushes back on the sender.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && rx_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = rx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 63) == 0) begin
        rx_idle = !rx_idle;
      end
    end
  end

  always @(posedge clk_i) begin
    rgb_pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rx_count++;
      if (rgb_expect_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected transaction: r=%0d g=%0d b=%0d a=%0d",
                   red_o, green_o, blue_o, alpha_out_o);
        end
      end else begin
        want = rgb_expect_q.pop_front();
        if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue ||
            alpha_out_o !== want.alpha) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                     want.red, want.green, want.blue, want.alpha,
                     red_o, green_o, blue_o, alpha_out_o);
          end
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    hue_i = '0;
    saturation_i = '0;
    lightness_i = '0;
    alpha_in_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      offer_pixel(dir_tab[i]);
    end

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      case ($urandom_range(0, 9))
        0:       row.hue = 16'($urandom_range(0, 359));
        1:       row.hue = $urandom_range(0, 1) ? 16'h8000 + 16'($urandom_range(0, 3))
                                                : 16'h7FFF - 16'($urandom_range(0, 3));
        default: row.hue = 16'($urandom);
      endcase
      row.sat = pick_level();
      row.light = pick_level();
      row.alpha = 8'($urandom);
      row.known = 1'b0;
      row.red = '0;
      row.green = '0;
      row.blue = '0;
      offer_pixel(row);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (rgb_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("hsl_to_rgb_converter_tb OK");
    end else begin
      $display("hsl_to_rgb_converter_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/hsl2rgb_pkg.sv
rtl/core/hsl_to_rgb_converter.sv
bench/hsl_to_rgb_converter_tb.sv
